// ===== hw/rtl/bblur_pkg.sv =====
// ============================================================================
// bblur_pkg
// Shared types, constants and the reciprocal table of the 3x3 RGB box blur.
// ============================================================================
package bblur_pkg;

    localparam int MAX_WIDTH    = 2048;
    localparam int COL_W        = $clog2(MAX_WIDTH);
    localparam int HEIGHT_LIMIT = 4096;
    localparam int HROW_W       = $clog2(HEIGHT_LIMIT);
    localparam int ROW_W        = 13;

    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 13;
    localparam int CFG_WIDTH_W  = 12;
    localparam int CFG_HEIGHT_W = 13;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

    localparam int RESET_WIDTH  = 640;
    localparam int RESET_HEIGHT = 480;

    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = FIFO_PTR_W + 1;

    localparam int SUM_W       = 12;
    localparam int CNT_W       = 4;
    localparam int RECIP_W     = 17;
    localparam int RECIP_SHIFT = 17;
    localparam int NUM_W       = SUM_W + 1;
    localparam int PROD_W      = NUM_W + RECIP_W;
    localparam int QUOT_W      = PROD_W - RECIP_SHIFT;
    localparam int CHANNEL_MAX = 255;

    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } pixel_t;

    typedef struct packed {
        logic   eof;
        pixel_t pix;
    } result_t;

    typedef struct packed {
        logic left_en;
        logic right_en;
        logic top_en;
        logic bottom_en;
    } nb_mask_t;

    // ceil(2^17 / (2*count)); exact for numerators below 4600
    function automatic logic [RECIP_W-1:0] bb_recip(input logic [CNT_W-1:0] cnt);
        logic [RECIP_W-1:0] r;
        begin
            case (cnt)
                4'd1:    r = 17'd65536;
                4'd2:    r = 17'd32768;
                4'd3:    r = 17'd21846;
                4'd4:    r = 17'd16384;
                4'd6:    r = 17'd10923;
                4'd9:    r = 17'd7282;
                default: r = '0;
            endcase
            return r;
        end
    endfunction

endpackage

// ===== hw/rtl/bblur_out_fifo.sv =====
// ============================================================================
// bblur_out_fifo
// Result queue between the blur pipeline and the master stream port.
// ============================================================================
module bblur_out_fifo
    import bblur_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push,
    input  result_t               push_data,
    input  logic                  pop,
    output result_t               head,
    output logic [FIFO_CNT_W-1:0] count
);

    result_t                 entry_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]   wr_ptr_reg;
    logic [FIFO_PTR_W-1:0]   rd_ptr_reg;
    logic [FIFO_CNT_W-1:0]   cnt_reg;
    logic [FIFO_CNT_W-1:0]   cnt_next;

    always_comb begin
        cnt_next = cnt_reg;
        if (push && !pop) begin
            cnt_next = cnt_reg + FIFO_CNT_W'(1);
        end else if (pop && !push) begin
            cnt_next = cnt_reg - FIFO_CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + FIFO_PTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + FIFO_PTR_W'(1);
            end
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign head  = entry_reg[rd_ptr_reg];
    assign count = cnt_reg;

endmodule

// ===== hw/rtl/box_blur_3x3_rgb.sv =====
// ============================================================================
// box_blur_3x3_rgb
// Streaming 3x3 box blur of an RGB frame using two line stores in one RAM.
// ============================================================================
// Pipeline: the request that completes a neighbourhood passes the RAM read, window
//   update, sum and reciprocal multiply before its result enters the output queue.
// Throughput: one request per cycle while the output queue has room; line RAM read and written once each.
// Reset: counters, window, pipeline and output queue cleared; geometry 640x480.
//   Line RAM is not cleared: entries outside the frame are masked.
module box_blur_3x3_rgb
    import bblur_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [23:0]           s_tdata,   // red_in, green_in, blue_in
    input  logic                  s_tuser,   // drain
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [23:0]           m_tdata,   // red_out, green_out, blue_out
    output logic                  m_tlast,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    // geometry and position
    logic [COL_W-1:0]  w_m1_reg;
    logic [HROW_W-1:0] h_m1_reg;
    logic [COL_W-1:0]  col_reg;
    logic [COL_W-1:0]  col_next;
    logic [ROW_W-1:0]  row_reg;
    logic [ROW_W-1:0]  row_next;

    logic              in_accept;
    logic              cfg_accept;
    logic              col_zero;
    logic              have;
    logic [ROW_W-1:0]  cen_row;
    logic [COL_W-1:0]  cen_col;
    logic              out_ok;
    logic              frame_end;
    nb_mask_t          mask_in;
    pixel_t            pix_in;
    logic [CFG_WIDTH_W-1:0]  wv;
    logic [CFG_HEIGHT_W-1:0] hv;

    // line RAM: upper line in the high half, middle line in the low half
    logic [47:0]       line_mem [MAX_WIDTH];
    logic [47:0]       rd_data_reg;
    logic [47:0]       fwd_data_reg;
    logic              fwd_sel_reg;
    logic [47:0]       line_rd;
    logic [47:0]       wr_data;

    // stage 1
    logic              p1_valid_reg;
    logic              p1_out_reg;
    logic              p1_eof_reg;
    nb_mask_t          p1_mask_reg;
    logic [COL_W-1:0]  p1_addr_reg;
    pixel_t            p1_pix_reg;

    // window [column][row]
    pixel_t            win_reg [3][3];

    // stage 2
    logic              p2_valid_reg;
    logic              p2_eof_reg;
    nb_mask_t          p2_mask_reg;
    logic [2:0]        col_en;
    logic [2:0]        row_en;
    logic [SUM_W-1:0]  sum_next [3];
    logic [1:0]        ncols;
    logic [1:0]        nrows;

    // stage 3
    logic              p3_valid_reg;
    logic              p3_eof_reg;
    logic [SUM_W-1:0]  p3_sum_reg [3];
    logic [CNT_W-1:0]  p3_cnt_reg;
    logic [NUM_W-1:0]  num [3];
    logic [PROD_W-1:0] prod [3];
    logic [QUOT_W-1:0] quot [3];
    logic [7:0]        mean [3];
    result_t           res;

    // output queue
    result_t                 q_head;
    logic [FIFO_CNT_W-1:0]   q_count;
    logic [FIFO_CNT_W:0]     occupancy;

    assign cfg_ready  = 1'b1;
    assign cfg_accept = cfg_valid && cfg_ready;
    assign in_accept  = s_tvalid && s_tready;
    assign pix_in     = s_tuser ? pixel_t'('0) : pixel_t'(s_tdata);
    assign wv         = cfg_data[CFG_WIDTH_W-1:0];
    assign hv         = cfg_data[CFG_HEIGHT_W-1:0];

    assign occupancy = {1'b0, q_count} + (FIFO_CNT_W+1)'(p1_out_reg)
                     + (FIFO_CNT_W+1)'(p2_valid_reg) + (FIFO_CNT_W+1)'(p3_valid_reg);
    assign s_tready  = occupancy < (FIFO_CNT_W+1)'(FIFO_DEPTH);

    always_comb begin
        col_zero  = (col_reg == '0);
        have      = col_zero ? (row_reg >= ROW_W'(2)) : (row_reg >= ROW_W'(1));
        cen_row   = col_zero ? (row_reg - ROW_W'(2)) : (row_reg - ROW_W'(1));
        cen_col   = col_zero ? w_m1_reg : (col_reg - COL_W'(1));
        out_ok    = have && (cen_row <= ROW_W'(h_m1_reg));
        frame_end = out_ok && (cen_row == ROW_W'(h_m1_reg)) && (cen_col == w_m1_reg);

        mask_in.left_en   = (cen_col != '0);
        mask_in.right_en  = (cen_col != w_m1_reg);
        mask_in.top_en    = (cen_row != '0);
        mask_in.bottom_en = (cen_row != ROW_W'(h_m1_reg));

        if (col_reg == w_m1_reg) begin
            col_next = '0;
            row_next = row_reg + ROW_W'(1);
        end else begin
            col_next = col_reg + COL_W'(1);
            row_next = row_reg;
        end
        if (frame_end) begin
            col_next = '0;
            row_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            w_m1_reg <= COL_W'(RESET_WIDTH - 1);
            h_m1_reg <= HROW_W'(RESET_HEIGHT - 1);
            col_reg  <= '0;
            row_reg  <= '0;
        end else if (cfg_accept &&
                     (cfg_index == REG_IMAGE_WIDTH || cfg_index == REG_IMAGE_HEIGHT)) begin
            if (cfg_index == REG_IMAGE_WIDTH) begin
                if (wv == '0) begin
                    w_m1_reg <= '0;
                end else if (32'(wv) > 32'(MAX_WIDTH)) begin
                    w_m1_reg <= COL_W'(MAX_WIDTH - 1);
                end else begin
                    w_m1_reg <= COL_W'(wv - CFG_WIDTH_W'(1));
                end
            end else begin
                if (hv == '0) begin
                    h_m1_reg <= '0;
                end else if (32'(hv) > 32'(HEIGHT_LIMIT)) begin
                    h_m1_reg <= HROW_W'(HEIGHT_LIMIT - 1);
                end else begin
                    h_m1_reg <= HROW_W'(hv - CFG_HEIGHT_W'(1));
                end
            end
            col_reg <= '0;
            row_reg <= '0;
        end else if (in_accept) begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // line RAM, one read and one write port
    always_ff @(posedge aclk) begin
        if (in_accept) begin
            rd_data_reg <= line_mem[col_reg];
        end
        if (p1_valid_reg) begin
            line_mem[p1_addr_reg] <= wr_data;
        end
    end

    // same-column write in the read cycle (one-pixel rows)
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fwd_sel_reg <= 1'b0;
        end else if (in_accept) begin
            fwd_sel_reg <= p1_valid_reg && (p1_addr_reg == col_reg);
        end
    end

    always_ff @(posedge aclk) begin
        fwd_data_reg <= wr_data;
    end

    assign line_rd = fwd_sel_reg ? fwd_data_reg : rd_data_reg;
    assign wr_data = {line_rd[23:0], p1_pix_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
            p1_out_reg   <= 1'b0;
        end else begin
            p1_valid_reg <= in_accept;
            p1_out_reg   <= in_accept && out_ok;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            p1_eof_reg  <= frame_end;
            p1_mask_reg <= mask_in;
            p1_addr_reg <= col_reg;
            p1_pix_reg  <= pix_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    win_reg[i][j] <= '0;
                end
            end
        end else if (p1_valid_reg) begin
            for (int j = 0; j < 3; j++) begin
                win_reg[0][j] <= win_reg[1][j];
                win_reg[1][j] <= win_reg[2][j];
            end
            win_reg[2][0] <= pixel_t'(line_rd[47:24]);
            win_reg[2][1] <= pixel_t'(line_rd[23:0]);
            win_reg[2][2] <= p1_pix_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p2_valid_reg <= 1'b0;
        end else begin
            p2_valid_reg <= p1_valid_reg && p1_out_reg;
        end
    end

    always_ff @(posedge aclk) begin
        p2_eof_reg  <= p1_eof_reg;
        p2_mask_reg <= p1_mask_reg;
    end

    // masked neighbourhood sums
    always_comb begin
        logic [SUM_W-1:0] csum [3][3];
        col_en = {p2_mask_reg.right_en, 1'b1, p2_mask_reg.left_en};
        row_en = {p2_mask_reg.bottom_en, 1'b1, p2_mask_reg.top_en};
        for (int i = 0; i < 3; i++) begin
            for (int k = 0; k < 3; k++) begin
                csum[i][k] = '0;
            end
            for (int j = 0; j < 3; j++) begin
                if (row_en[j]) begin
                    csum[i][0] = csum[i][0] + SUM_W'(win_reg[i][j].red);
                    csum[i][1] = csum[i][1] + SUM_W'(win_reg[i][j].green);
                    csum[i][2] = csum[i][2] + SUM_W'(win_reg[i][j].blue);
                end
            end
        end
        for (int k = 0; k < 3; k++) begin
            sum_next[k] = '0;
            for (int i = 0; i < 3; i++) begin
                if (col_en[i]) begin
                    sum_next[k] = sum_next[k] + csum[i][k];
                end
            end
        end
        ncols = 2'd1 + 2'(p2_mask_reg.left_en) + 2'(p2_mask_reg.right_en);
        nrows = 2'd1 + 2'(p2_mask_reg.top_en) + 2'(p2_mask_reg.bottom_en);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p3_valid_reg <= 1'b0;
        end else begin
            p3_valid_reg <= p2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        p3_eof_reg <= p2_eof_reg;
        p3_cnt_reg <= CNT_W'(ncols * nrows);
        for (int k = 0; k < 3; k++) begin
            p3_sum_reg[k] <= sum_next[k];
        end
    end

    // rounded mean: (2*sum + count) / (2*count) by reciprocal multiply
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            num[k]  = {p3_sum_reg[k], 1'b0} + NUM_W'(p3_cnt_reg);
            prod[k] = PROD_W'(num[k]) * PROD_W'(bb_recip(p3_cnt_reg));
            quot[k] = prod[k][PROD_W-1:RECIP_SHIFT];
            mean[k] = (quot[k] > QUOT_W'(CHANNEL_MAX)) ? 8'(CHANNEL_MAX) : quot[k][7:0];
        end
        res.eof       = p3_eof_reg;
        res.pix.red   = mean[0];
        res.pix.green = mean[1];
        res.pix.blue  = mean[2];
    end

    bblur_out_fifo u_out_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (p3_valid_reg),
        .push_data (res),
        .pop       (m_tvalid && m_tready),
        .head      (q_head),
        .count     (q_count)
    );

    assign m_tvalid = (q_count != '0);
    assign m_tdata  = q_head.pix;
    assign m_tlast  = q_head.eof;

endmodule

// ===== hw/rtl/bblur_checker.sv =====
// ============================================================================
// bblur_checker
// Port-level checks of the box blur stream behaviour, bound to the top level.
// ============================================================================
module bblur_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic        m_tlast
);

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed while stalled");

    // queue is empty after reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result present after reset");

    // a result only appears from an earlier request
    a_no_invent: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 4))
        else $error("result without a matching request");

    // an empty queue never holds off the input
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output queue");

endmodule

bind box_blur_3x3_rgb bblur_checker u_bblur_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
